// ----- src/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper with scanline IRQ:
// item and result layouts, address decode codes and configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  // Number of character bank slots.
  localparam int unsigned CHAR_SLOTS_DEF = 8;

  // Configuration register layout and reset values.
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic        CHAR_ROM_RST  = 1'b1;
  localparam logic        FOUR_SCR_RST  = 1'b0;

  // Configuration register indexes (byte address bits above the word offset).
  typedef enum logic {
    CFG_CHAR_ROM = 1'b0,
    CFG_FOUR_SCR = 1'b1
  } cfg_idx_e;

  // Request kinds on the input stream.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  // Update kinds reported in the result.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PRG    = 2'd1,
    KIND_CHR    = 2'd2,
    KIND_MIRROR = 2'd3
  } kind_e;

  // Address blocks, taken from address bits 15..12.
  localparam logic [3:0] BLK_PRG0  = 4'h8;
  localparam logic [3:0] BLK_PRG1  = 4'h9;
  localparam logic [3:0] BLK_CHR_B = 4'hB;
  localparam logic [3:0] BLK_CHR_C = 4'hC;
  localparam logic [3:0] BLK_CHR_D = 4'hD;
  localparam logic [3:0] BLK_CHR_E = 4'hE;
  localparam logic [3:0] BLK_IRQ   = 4'hF;

  // Register selects inside the IRQ block (address bits 1..0).
  typedef enum logic [1:0] {
    IRQ_RELOAD = 2'd0,
    IRQ_CTRL   = 2'd1,
    IRQ_ACK    = 2'd2,
    IRQ_NONE   = 2'd3
  } irq_sel_e;

  // Control register bits in an IRQ control write.
  localparam int unsigned IRQ_CTRL_EN_BIT   = 1;
  localparam int unsigned IRQ_CTRL_MODE_BIT = 2;

  typedef struct packed {
    logic char_rom_present;
    logic four_screen_layout;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] address;
    logic [7:0]  data;
    logic        rendering_on;
  } item_t;

  typedef struct packed {
    kind_e       update_kind;
    logic [2:0]  slot;
    logic [7:0]  bank_number;
    logic [1:0]  mirror_mode;
    logic        irq_raise;
    logic        irq_clear;
  } result_t;

endpackage

`default_nettype wire

// ----- src/cbm_core.sv -----
// ----------------------------------------------------------------------------
// cbm_core
// Mapper register file and scanline counter. Decodes one request per cycle,
// updates the bank, mirroring and IRQ state and forms the matching result.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_core #(
  parameter int unsigned CharSlots = cbm_pkg::CHAR_SLOTS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cbm_pkg::cfg_t   cfg_i,
  input  wire logic            req_valid_i,
  input  wire cbm_pkg::item_t  req_i,
  output cbm_pkg::result_t     res_o
);
  import cbm_pkg::*;

  localparam int unsigned SlotW = $clog2(CharSlots);

  logic [4:0]       prg_q [2];
  logic [4:0]       prg_d [2];
  logic [7:0]       chr_q [CharSlots];
  logic [7:0]       chr_d [CharSlots];
  logic [1:0]       mirror_q, mirror_d;
  logic             irq_en_q, irq_en_d;
  logic [7:0]       reload_q, reload_d;
  logic [7:0]       count_q, count_d;
  logic             mode_q, mode_d;

  logic [3:0]       blk;
  logic [3:0]       chr_off;
  logic [2:0]       chr_idx;
  logic [SlotW-1:0] chr_sel;
  logic [7:0]       chr_new;
  irq_sel_e         irq_sel;

  // Character slot: two slots per block from $B000 upwards, A1 picks one.
  assign blk     = req_i.address[15:12];
  assign chr_off = blk - BLK_CHR_B;
  assign chr_idx = {chr_off[1:0], req_i.address[1]};
  assign chr_sel = SlotW'(chr_idx);
  assign irq_sel = irq_sel_e'(req_i.address[1:0]);

  // A0 picks which nibble of the selected character bank is replaced.
  always_comb begin
    if (req_i.address[0]) begin
      chr_new = {req_i.data[3:0], chr_q[chr_sel][3:0]};
    end else begin
      chr_new = {chr_q[chr_sel][7:4], req_i.data[3:0]};
    end
  end

  // Decode the request and work out the next state and the result.
  always_comb begin
    prg_d    = prg_q;
    chr_d    = chr_q;
    mirror_d = mirror_q;
    irq_en_d = irq_en_q;
    reload_d = reload_q;
    count_d  = count_q;
    mode_d   = mode_q;
    res_o    = '0;

    if (req_i.op == OP_TICK) begin
      if (irq_en_q && req_i.rendering_on) begin
        if (count_q == 8'd0) begin
          count_d         = reload_q;
          res_o.irq_raise = 1'b1;
        end else begin
          count_d = count_q - 8'd1;
        end
      end
    end else begin
      unique case (blk)
        BLK_PRG0: begin
          prg_d[0]          = req_i.data[4:0];
          res_o.update_kind = KIND_PRG;
          res_o.bank_number = {3'b000, req_i.data[4:0]};
        end
        BLK_PRG1: begin
          if (req_i.address[1]) begin
            mirror_d = req_i.data[1:0];
            if (!cfg_i.four_screen_layout) begin
              res_o.update_kind = KIND_MIRROR;
            end
          end else begin
            prg_d[1]          = req_i.data[4:0];
            res_o.update_kind = KIND_PRG;
            res_o.slot        = 3'd1;
            res_o.bank_number = {3'b000, req_i.data[4:0]};
          end
        end
        BLK_CHR_B, BLK_CHR_C, BLK_CHR_D, BLK_CHR_E: begin
          if (cfg_i.char_rom_present) begin
            chr_d[chr_sel]    = chr_new;
            res_o.update_kind = KIND_CHR;
            res_o.slot        = chr_idx;
            res_o.bank_number = chr_new;
          end
        end
        BLK_IRQ: begin
          unique case (irq_sel)
            IRQ_RELOAD: reload_d = req_i.data;
            IRQ_CTRL: begin
              mode_d   = req_i.data[IRQ_CTRL_MODE_BIT];
              irq_en_d = req_i.data[IRQ_CTRL_EN_BIT];
              if (req_i.data[IRQ_CTRL_EN_BIT]) begin
                count_d = reload_q;
              end
            end
            IRQ_ACK: begin
              irq_en_d        = 1'b0;
              res_o.irq_clear = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    res_o.mirror_mode = mirror_d;
  end

  // State registers; they move only when a request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_q    <= '{default: '0};
      chr_q    <= '{default: '0};
      mirror_q <= '0;
      irq_en_q <= 1'b0;
      reload_q <= '0;
      count_q  <= '0;
      mode_q   <= 1'b0;
    end else if (req_valid_i) begin
      prg_q    <= prg_d;
      chr_q    <= chr_d;
      mirror_q <= mirror_d;
      irq_en_q <= irq_en_d;
      reload_q <= reload_d;
      count_q  <= count_d;
      mode_q   <= mode_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/cartridge_bank_mapper_scanline_irq_unit.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_scanline_irq_unit
// Cartridge bank mapper with a scanline interrupt counter. Each request is a
// CPU register write or a scanline tick and yields exactly one result.
// ----------------------------------------------------------------------------
//
//  Port group  Direction  Carries
//  s_axis_*    in         requests: op in tuser, address/data/rendering_on
//  m_axis_*    out        results: update_kind in tuser, slot/bank/mirror/irq
//  p*          in/out     APB: 0x0 char_rom_present, 0x4 four_screen_layout
//
// A request is decoded and the mapper state updated in the cycle it is taken;
// its result is registered, in the skid register while the result register is full.
// A two-entry output buffer (result register plus skid register) lets one
// request per cycle through; s_axis_tready only falls while both are full.
// Reset clears all bank, mirroring and IRQ state and loads the configuration
// defaults (character ROM present, no four-screen layout).
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_scanline_irq_unit #(
  parameter int unsigned CharSlots = cbm_pkg::CHAR_SLOTS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] address, [23:16] data, [24] rendering_on, [31:25] zero
  input  wire logic [31:0]                     s_axis_tdata,
  // [0] op
  input  wire logic [0:0]                      s_axis_tuser,
  // Output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [2:0] slot, [10:3] bank_number, [12:11] mirror_mode, [13] irq_raise,
  // [14] irq_clear, [15] zero
  output logic [15:0]                          m_axis_tdata,
  // [1:0] update_kind
  output logic [1:0]                           m_axis_tuser,
  // Configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [cbm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cbm_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import cbm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e cfg_sel;
  logic     cfg_wr;

  item_t    req;
  logic     push, pop;
  result_t  res;
  result_t  out_q, skid_q;
  logic     out_vld_q, skid_vld_q;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_sel = cfg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (cfg_sel)
        CFG_CHAR_ROM: cfg_d.char_rom_present   = pwdata[0];
        CFG_FOUR_SCR: cfg_d.four_screen_layout = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CFG_CHAR_ROM: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_q.char_rom_present};
      CFG_FOUR_SCR: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_q.four_screen_layout};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.char_rom_present   <= CHAR_ROM_RST;
      cfg_q.four_screen_layout <= FOUR_SCR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Unpack the request.
  assign req.op           = op_e'(s_axis_tuser[0]);
  assign req.address      = s_axis_tdata[15:0];
  assign req.data         = s_axis_tdata[23:16];
  assign req.rendering_on = s_axis_tdata[24];

  assign s_axis_tready = !skid_vld_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_vld_q && m_axis_tready;

  cbm_core #(
    .CharSlots (CharSlots)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (push),
    .req_i       (req),
    .res_o       (res)
  );

  // Result register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (pop) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (out_vld_q && !pop) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // Pack the result.
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.update_kind;
  assign m_axis_tdata  = {1'b0, out_q.irq_clear, out_q.irq_raise, out_q.mirror_mode,
                          out_q.bank_number, out_q.slot};

endmodule

`default_nettype wire

// ----- src/cbm_checker.sv -----
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks on the bank mapper: buffering, result consistency and the
// stream hold rule, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        pready
);
  import cbm_pkg::*;

  // The input side only stalls while a result is waiting.
  a_ready_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // A request taken into an empty unit shows a result in the next cycle.
  a_result_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("request taken without a following result");

  // A tick never reports a bank update, and a write never raises the IRQ.
  a_raise_alone: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[13]) |->
      (m_axis_tuser == KIND_NONE) && !m_axis_tdata[14])
    else $error("IRQ raise combined with a register write result");

  // A mirroring update carries no slot and no bank number.
  a_mirror_clean: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_MIRROR)) |->
      (m_axis_tdata[10:0] == 11'd0))
    else $error("mirroring result with slot or bank set");

  // A stalled result holds.
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && pready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind cartridge_bank_mapper_scanline_irq_unit cbm_checker u_cbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);

`default_nettype wire

// ----- sim/cartridge_bank_mapper_scanline_irq_unit_tb.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_scanline_irq_unit_tb
// Self-checking testbench for the cartridge bank mapper with scanline IRQ.
// Requests are written and ticks sent on the input stream. A mapper model
// inside the bench predicts one result per request, and a checker compares
// each result taken from the output stream against the oldest prediction.
// Both stream sides stall at random. The cartridge options are changed over
// the APB port between phases, while nothing is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_scanline_irq_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbm_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;

  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic [CFG_DATA_W-1:0] prdata;
  logic        pready;

  // Mapper state as the bench expects it to be.
  logic [4:0] prg_bank [2];
  logic [7:0] chr_bank [CHAR_SLOTS_DEF];
  logic [1:0] mirror_sel;
  logic       irq_on;
  logic [7:0] reload_val;
  logic [7:0] line_count;
  logic       mode_flag;
  logic       chr_rom_cfg;
  logic       four_scr_cfg;

  result_t     expected_results [$];
  int unsigned mismatches;
  int unsigned stall_cycles;
  logic        idle_on;

  cartridge_bank_mapper_scanline_irq_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Works out the result of one request and advances the mapper state.
  function automatic result_t predict_mapper(item_t it);
    result_t    r;
    logic [3:0] blk;
    logic [2:0] idx;
    logic [7:0] v;
    r = '0;
    blk = it.address[15:12];
    if (it.op == OP_TICK) begin
      // A tick only counts with rendering on and the IRQ enabled.
      if (irq_on && it.rendering_on) begin
        if (line_count == 8'd0) begin
          line_count = reload_val;
          r.irq_raise = 1'b1;
        end else begin
          line_count = line_count - 8'd1;
        end
      end
    end else begin
      case (blk)
        BLK_PRG0: begin
          prg_bank[0] = it.data[4:0];
          r.update_kind = KIND_PRG;
          r.slot = 3'd0;
          r.bank_number = {3'b000, prg_bank[0]};
        end
        BLK_PRG1: begin
          if (it.address[1]) begin
            // The register is written even when the layout hides the change.
            mirror_sel = it.data[1:0];
            if (!four_scr_cfg) r.update_kind = KIND_MIRROR;
          end else begin
            prg_bank[1] = it.data[4:0];
            r.update_kind = KIND_PRG;
            r.slot = 3'd1;
            r.bank_number = {3'b000, prg_bank[1]};
          end
        end
        BLK_CHR_B, BLK_CHR_C, BLK_CHR_D, BLK_CHR_E: begin
          if (chr_rom_cfg) begin
            idx = {2'(blk - BLK_CHR_B), it.address[1]};
            v = chr_bank[idx];
            if (it.address[0]) v[7:4] = it.data[3:0];
            else v[3:0] = it.data[3:0];
            chr_bank[idx] = v;
            r.update_kind = KIND_CHR;
            r.slot = idx;
            r.bank_number = v;
          end
        end
        BLK_IRQ: begin
          case (irq_sel_e'(it.address[1:0]))
            IRQ_RELOAD: reload_val = it.data;
            IRQ_CTRL: begin
              mode_flag = it.data[IRQ_CTRL_MODE_BIT];
              irq_on = it.data[IRQ_CTRL_EN_BIT];
              if (irq_on) line_count = reload_val;
            end
            IRQ_ACK: begin
              irq_on = 1'b0;
              r.irq_clear = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    r.mirror_mode = mirror_sel;
    return r;
  endfunction

  // Sends one request, with a random gap in front, and records its result.
  task automatic send_request(input item_t it);
    logic taken;
    while (idle_on && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, it.rendering_on, it.data, it.address};
    s_tuser  <= it.op;
    // tready is sampled mid-cycle, where it is stable up to the next edge.
    forever begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
      if (taken) break;
    end
    expected_results.push_back(predict_mapper(it));
  endtask

  task automatic cpu_write(input logic [15:0] a, input logic [7:0] d);
    item_t it;
    it.op = OP_WRITE;
    it.address = a;
    it.data = d;
    it.rendering_on = 1'($urandom);
    send_request(it);
  endtask

  task automatic scanline(input logic rendering);
    item_t it;
    it.op = OP_TICK;
    it.address = 16'($urandom);
    it.data = 8'($urandom);
    it.rendering_on = rendering;
    send_request(it);
  endtask

  // Lets every outstanding result come out before the block is reconfigured.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_transfer(input cfg_idx_e idx, input logic wr, input logic value);
    logic rdy;
    logic [CFG_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(CFG_DATA_W-1){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    forever begin
      @(negedge clk_i);
      rdy = pready;
      rd = prdata;
      @(posedge clk_i);
      if (rdy) break;
    end
    if (!wr && rd[0] !== value) begin
      mismatches++;
      $display("%0t: register %0d read back: expected %0b, got %0b", $time, idx, value, rd[0]);
    end
  endtask

  // Writes both cartridge options and reads each one back.
  task automatic set_layout(input logic chr_rom, input logic four_scr);
    drain_results();
    apb_transfer(CFG_CHAR_ROM, 1'b1, chr_rom);
    chr_rom_cfg = chr_rom;
    apb_transfer(CFG_FOUR_SCR, 1'b1, four_scr);
    four_scr_cfg = four_scr;
    apb_transfer(CFG_CHAR_ROM, 1'b0, chr_rom);
    apb_transfer(CFG_FOUR_SCR, 1'b0, four_scr);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Bank and mirroring registers under the reset options.
  task automatic test_register_map();
    cpu_write(16'h8000, 8'hFF);
    cpu_write(16'h8FFF, 8'h00);
    cpu_write(16'h9000, 8'h1F);
    cpu_write(16'h9FF1, 8'hA5);
    cpu_write(16'h9002, 8'h03);
    cpu_write(16'h9003, 8'h02);
    // Unmapped areas and the unused IRQ register select leave everything alone.
    cpu_write(16'h0000, 8'hFF);
    cpu_write(16'h7FFF, 8'h12);
    cpu_write(16'hA000, 8'h33);
    cpu_write(16'hFFFF, 8'hAA);
    // Character nibbles at the first and last slots.
    cpu_write(16'hB000, 8'hFF);
    cpu_write(16'hB001, 8'h5A);
    cpu_write(16'hE003, 8'hFF);
    cpu_write(16'hE002, 8'hC3);
  endtask

  // Scanline counter: expiry at zero, idle ticks, reload and acknowledge.
  task automatic test_scanline_irq();
    cpu_write(16'hF000, 8'h00);
    cpu_write(16'hF001, 8'h02);
    scanline(1'b1);
    scanline(1'b0);
    cpu_write(16'hF000, 8'hFF);
    cpu_write(16'hF001, 8'h06);
    scanline(1'b1);
    cpu_write(16'hF002, 8'h00);
    scanline(1'b1);
  endtask

  // No character ROM and a four-screen layout hide their updates.
  task automatic test_cartridge_options();
    set_layout(1'b0, 1'b1);
    cpu_write(16'hC001, 8'h9F);
    cpu_write(16'h9002, 8'h01);
    cpu_write(16'h8000, 8'h0C);
    set_layout(1'b1, 1'b0);
    cpu_write(16'hC001, 8'h9F);
  endtask

  // Mostly mapped writes and counting ticks, with some arbitrary addresses.
  task automatic test_random_traffic(input int unsigned count, input int unsigned quiet);
    item_t       it;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      idle_on = (n >= quiet);
      it.address = 16'($urandom);
      it.data = 8'($urandom);
      it.rendering_on = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 40) begin
        it.op = OP_TICK;
      end else begin
        it.op = OP_WRITE;
        if (pick >= 48 && pick < 62) begin
          it.address[15:12] = BLK_IRQ;
          // Short reload values make the counter expire often.
          if (it.address[1:0] == IRQ_RELOAD && $urandom_range(3) != 0)
            it.data = 8'($urandom_range(6));
        end else if (pick >= 62 && pick < 72) begin
          it.address[15:12] = $urandom_range(1) ? BLK_PRG1 : BLK_PRG0;
        end else if (pick >= 72) begin
          it.address[15:12] = 4'($urandom_range(8, 15));
        end
      end
      send_request(it);
    end
    idle_on = 1'b1;
  endtask

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    m_tready <= !idle_on || ($urandom_range(99) >= 25);
  end

  // Result checker and stall watchdog, both sampling mid-cycle.
  always @(negedge clk_i) begin
    result_t got;
    result_t exp;
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready) begin
        got.update_kind = kind_e'(m_axis_tuser);
        got.slot        = m_axis_tdata[2:0];
        got.bank_number = m_axis_tdata[10:3];
        got.mirror_mode = m_axis_tdata[12:11];
        got.irq_raise   = m_axis_tdata[13];
        got.irq_clear   = m_axis_tdata[14];
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding: kind=%0d slot=%0d bank=%02h",
                   $time, got.update_kind, got.slot, got.bank_number);
        end else begin
          exp = expected_results.pop_front();
          if (got !== exp) begin
            mismatches++;
            $display("%0t: expected kind=%0d slot=%0d bank=%02h mirror=%0d raise=%0b clear=%0b",
                     $time, exp.update_kind, exp.slot, exp.bank_number, exp.mirror_mode,
                     exp.irq_raise, exp.irq_clear);
            $display("%0t:      got kind=%0d slot=%0d bank=%02h mirror=%0d raise=%0b clear=%0b",
                     $time, got.update_kind, got.slot, got.bank_number, got.mirror_mode,
                     got.irq_raise, got.irq_clear);
          end
        end
      end
      if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) || psel) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    mismatches   = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    prg_bank[0]  = '0;
    prg_bank[1]  = '0;
    for (int i = 0; i < CHAR_SLOTS_DEF; i++) chr_bank[i] = '0;
    mirror_sel   = '0;
    irq_on       = 1'b0;
    reload_val   = '0;
    line_count   = '0;
    mode_flag    = 1'b0;
    chr_rom_cfg  = CHAR_ROM_RST;
    four_scr_cfg = FOUR_SCR_RST;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_map();
    test_scanline_irq();
    test_cartridge_options();
    // Random traffic under every combination of the options.
    test_random_traffic(210, 0);
    set_layout(1'b0, 1'b0);
    test_random_traffic(210, 0);
    set_layout(1'b1, 1'b1);
    test_random_traffic(210, 160);
    set_layout(1'b0, 1'b1);
    test_random_traffic(210, 0);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/cbm_pkg.sv
src/cbm_core.sv
src/cartridge_bank_mapper_scanline_irq_unit.sv
src/cbm_checker.sv
sim/cartridge_bank_mapper_scanline_irq_unit_tb.sv
